FILE: design/fsp2_pkg.sv
// fsp2_pkg: shared types and constants for the float32 power-of-two scaler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package fsp2_pkg;
  localparam int unsigned ExpW = 8;
  localparam int unsigned ManW = 23;
  localparam logic [ExpW-1:0] ExpMax = 8'hFF;

  typedef struct packed {
    logic [31:0]        value_bits;
    logic signed [15:0] scale_exponent;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        range_error;
  } out_item_t;
endpackage
`default_nettype wire

FILE: design/fsp2_datapath.sv
// fsp2_datapath: combinational scale of a binary32 pattern by 2^scale
// depends on fsp2_pkg
`timescale 1ns / 1ps
`default_nettype none
module fsp2_datapath import fsp2_pkg::*; (
  input  wire in_item_t  item_i,
  output out_item_t      res_o
);
  logic             sign;
  logic [ExpW-1:0]  expo;
  logic [ManW-1:0]  mant;
  logic [4:0]       lz;
  logic [ManW:0]    sig;
  logic signed [17:0] e;
  logic [4:0]       sh;
  logic [ManW:0]    q;
  logic [ManW:0]    rem;
  logic [ManW+1:0]  half;
  logic [ManW+1:0]  qr;

  assign sign = item_i.value_bits[31];
  assign expo = item_i.value_bits[30:23];
  assign mant = item_i.value_bits[ManW-1:0];

  // normalization shift for a subnormal: leading zero count of {1'b0, mant}
  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < ManW; i++) begin
      if (mant[i]) lz = 5'(ManW - i);
    end
  end

  always_comb begin
    if (expo == '0) begin
      sig = {1'b0, mant} << lz;
      e   = 18'sd1 - 18'(signed'({13'd0, lz})) + 18'(item_i.scale_exponent);
    end else begin
      sig = {1'b1, mant};
      e   = 18'(signed'({10'd0, expo})) + 18'(item_i.scale_exponent);
    end
    sh   = 5'(18'sd1 - e);
    q    = sig >> sh;
    rem  = sig & ((24'd1 << sh) - 24'd1);
    // half needs 25 bits for the deepest shift
    half = 25'd1 << (sh - 5'd1);
    qr   = {1'b0, q} + 25'(({1'b0, rem} > half) || (({1'b0, rem} == half) && q[0]));

    res_o.range_error = 1'b0;
    if (expo == ExpMax || (expo == '0 && mant == '0)) begin
      res_o.result_bits = item_i.value_bits;
    end else if (e >= 18'sd255) begin
      res_o.result_bits = {sign, ExpMax, 23'd0};
      res_o.range_error = 1'b1;
    end else if (e >= 18'sd1) begin
      res_o.result_bits = {sign, e[7:0], sig[ManW-1:0]};
    end else if (e < -18'sd24) begin
      res_o.result_bits = {sign, 31'd0};
    end else begin
      res_o.result_bits = {sign, 7'd0, qr[ManW:0]};
    end
  end
endmodule
`default_nettype wire

FILE: design/float32_scale_by_power_of_two_core.sv
// float32_scale_by_power_of_two_core: binary32 ldexp with valid/ready
// result registered; valid in the cycle after the input transaction
// throughput one transaction per cycle; input accepted while output is free or taken
// reset clears the output valid only; no other state
// depends on fsp2_pkg, fsp2_datapath
`timescale 1ns / 1ps
`default_nettype none
module float32_scale_by_power_of_two_core import fsp2_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic      out_valid_o,
  input  wire       out_ready_i,
  output out_item_t out_data_o
);
  out_item_t res;
  out_item_t data_q;
  logic      valid_q;

  fsp2_datapath u_dp (.item_i(in_data_i), .res_o(res));

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= res;
    end
  end
endmodule
`default_nettype wire

FILE: design/fsp2_checker.sv
// fsp2_checker: port-level assertions for the scaler core
// depends on fsp2_pkg; bound to float32_scale_by_power_of_two_core
`timescale 1ns / 1ps
`default_nettype none
module fsp2_checker import fsp2_pkg::*; (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_o,
  input wire       out_valid_o,
  input wire       out_ready_i,
  input wire out_item_t out_data_o
);
  // an accepted transaction shows a result next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o) else $error("result missing");
  // a free output never blocks input
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o) else $error("ready dropped");
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");
  // range flag only with infinity
  a_inf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.range_error |->
    out_data_o.result_bits[30:0] == 31'h7F800000) else $error("bad range flag");
endmodule

bind float32_scale_by_power_of_two_core fsp2_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
);
`default_nettype wire
